@@ design/mraa_pkg.sv @@
package mraa_pkg;

	localparam int MAX_FREE_RECTS_DEF = 64;
	localparam int COORD_BITS_DEF = 13;
	localparam int FIELD_W = 13;
	localparam int BORDER_W = 8;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W = 1;

	localparam logic [FIELD_W-1:0] ATLAS_RESET = 13'd1024;

	localparam logic [0:0] CMD_ALLOC = 1'b0;
	localparam logic [0:0] CMD_RESET = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_DROP = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ATLAS_HEIGHT = 1'b1;

	typedef struct packed {
		logic [0:0] command;
		logic [FIELD_W-1:0] tex_width;
		logic [FIELD_W-1:0] tex_height;
		logic [BORDER_W-1:0] border;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [FIELD_W-1:0] left;
		logic [FIELD_W-1:0] top;
		logic [FIELD_W-1:0] right;
		logic [FIELD_W-1:0] bottom;
	} rsp_t;

	typedef enum logic [3:0] {
		S_BOOT,
		S_IDLE,
		S_SEARCH_RD,
		S_SEARCH,
		S_COPY_RD,
		S_COPY,
		S_SPLIT_RD,
		S_SPLIT,
		S_FRAG,
		S_COV_RD,
		S_COV,
		S_PRUNE_RD,
		S_PRUNE,
		S_APPEND,
		S_DONE
	} state_t;

endpackage

@@ design/maxrects_atlas_allocator_core.sv @@
// Rectangle allocator for a texture atlas with a list of maximal free
// rectangles. A request is either a reset, which rebuilds the list as one
// rectangle covering the current atlas size, or an allocation, which pads the
// texture by twice the border, rounds both sides up to a multiple of 4, and
// places it in the fitting free rectangle with the smallest top edge (then
// smallest left edge). Every free rectangle that overlaps the placement is
// cut into up to four strips; each strip is inserted only if no free
// rectangle covers it, and any free rectangle it covers is pruned. The
// response carries the inner rectangle without the border; status 1 means
// nothing fit, status 2 means a rectangle was dropped as the list was full.
// The free list and its scratch copy live in two memories with registered
// reads, walked by one sequencer with one shared comparator set; every list
// entry is handled in a read state and then in a compare state. The block
// takes one request at a time: it stalls its input from acceptance until the
// response has been taken, and accepts again in the cycle after that. After
// reset a boot state writes the initial full rectangle while the input is
// stalled. A reset request passes through the cover, prune and append states
// before its response shows. An allocation searches the whole list (a no-fit
// response follows the search directly), copies the list to scratch, and then
// reads each copied entry and cuts it into its strips. Each strip or untouched
// entry is inserted into the current list with a cover pass, a prune pass and
// an append, so the time grows with the square of the list depth. Atlas size
// registers take effect at the next reset request.
module maxrects_atlas_allocator_core
	import mraa_pkg::*;
#(
	parameter int MAX_FREE_RECTS = MAX_FREE_RECTS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output rsp_t out_data,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = (MAX_FREE_RECTS > 1) ? $clog2(MAX_FREE_RECTS) : 1;
	localparam int CW = $clog2(MAX_FREE_RECTS + 1);
	localparam int RW = 4 * COORD_BITS;
	// Arithmetic width: enough for coordinate plus padded size.
	localparam int XW = (COORD_BITS > 15 ? COORD_BITS : 15) + 2;
	localparam logic [XW-1:0] CMAX = XW'((1 << COORD_BITS) - 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_FREE_RECTS);

	typedef struct packed {
		logic [XW-1:0] x0;
		logic [XW-1:0] z0;
		logic [XW-1:0] x1;
		logic [XW-1:0] z1;
	} rect_t;

	function automatic rect_t unpack_r(input logic [RW-1:0] v);
		rect_t r;
		r.x0 = XW'(v[4*COORD_BITS-1:3*COORD_BITS]);
		r.z0 = XW'(v[3*COORD_BITS-1:2*COORD_BITS]);
		r.x1 = XW'(v[2*COORD_BITS-1:COORD_BITS]);
		r.z1 = XW'(v[COORD_BITS-1:0]);
		return r;
	endfunction

	function automatic logic [RW-1:0] pack_r(input rect_t r);
		return {r.x0[COORD_BITS-1:0], r.z0[COORD_BITS-1:0],
			r.x1[COORD_BITS-1:0], r.z1[COORD_BITS-1:0]};
	endfunction

	// The whole atlas as one rectangle, sizes saturated to the coordinate range.
	function automatic rect_t full_rect(input logic [FIELD_W-1:0] w,
		input logic [FIELD_W-1:0] h);
		rect_t r;
		r.x0 = '0;
		r.z0 = '0;
		r.x1 = (XW'(w) > CMAX) ? CMAX : XW'(w);
		r.z1 = (XW'(h) > CMAX) ? CMAX : XW'(h);
		return r;
	endfunction

	// Configuration registers.
	logic [FIELD_W-1:0] atlas_w_q, atlas_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atlas_w_q <= ATLAS_RESET;
			atlas_h_q <= ATLAS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ATLAS_WIDTH: atlas_w_q <= cfg_data;
				REG_ATLAS_HEIGHT: atlas_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Memories.
	logic [RW-1:0] free_mem [MAX_FREE_RECTS];
	logic [RW-1:0] scr_mem [MAX_FREE_RECTS];
	logic [RW-1:0] free_rd_q, scr_rd_q;
	logic free_we, scr_we;
	logic [AW-1:0] free_waddr, free_raddr, scr_waddr, scr_raddr;
	logic [RW-1:0] free_wdata, scr_wdata;

	always_ff @(posedge clk) begin
		if (free_we) free_mem[free_waddr] <= free_wdata;
		free_rd_q <= free_mem[free_raddr];
	end

	always_ff @(posedge clk) begin
		if (scr_we) scr_mem[scr_waddr] <= scr_wdata;
		scr_rd_q <= scr_mem[scr_raddr];
	end

	// Control registers.
	state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;     // entries in the free list
	logic [CW-1:0] idx_q, idx_d;         // search, copy and split index
	logic [CW-1:0] ins_idx_q, ins_idx_d; // read index of the insert passes
	logic [CW-1:0] wr_q, wr_d;           // compaction write index
	logic [CW-1:0] n_q, n_d;             // entries in scratch
	logic [2:0] frag_q, frag_d;          // next strip of current scratch entry
	logic found_q, found_d;
	logic drop_q, drop_d;
	logic cmd_q, cmd_d;
	logic out_valid_q, out_valid_d;
	// Payload registers.
	rect_t best_q, best_d;
	rect_t f_q, f_d;                     // scratch entry being split
	rect_t ins_q, ins_d;                 // rectangle being inserted
	logic [XW-1:0] need_w_q, need_w_d, need_h_q, need_h_d;
	logic [BORDER_W-1:0] border_q, border_d;
	rsp_t rsp_q, rsp_d;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = rsp_q;

	// Shared compare unit: c_r is the list entry read, s_r the scratch entry.
	rect_t c_r, s_r;
	logic covered, contained, apart;
	logic [XW-1:0] cw, ch;
	logic fits, better;

	always_comb begin
		c_r = unpack_r(free_rd_q);
		s_r = unpack_r(scr_rd_q);
		covered = c_r.x0 <= ins_q.x0 && c_r.x1 >= ins_q.x1 &&
			c_r.z0 <= ins_q.z0 && c_r.z1 >= ins_q.z1;
		contained = ins_q.x0 <= c_r.x0 && ins_q.x1 >= c_r.x1 &&
			ins_q.z0 <= c_r.z0 && ins_q.z1 >= c_r.z1;
		cw = (c_r.x1 >= c_r.x0) ? c_r.x1 - c_r.x0 : '0;
		ch = (c_r.z1 >= c_r.z0) ? c_r.z1 - c_r.z0 : '0;
		fits = (need_w_q <= cw) && (need_h_q <= ch);
		better = !found_q || c_r.z0 < best_q.z0 ||
			(c_r.z0 == best_q.z0 && c_r.x0 < best_q.x0);
		apart = best_q.x0 >= s_r.x1 || s_r.x0 >= best_q.x1 ||
			best_q.z0 >= s_r.z1 || s_r.z0 >= best_q.z1 ||
			best_q.x0 >= best_q.x1 || best_q.z0 >= best_q.z1 ||
			s_r.x0 >= s_r.x1 || s_r.z0 >= s_r.z1;
	end

	// Padded sizes of the incoming request.
	logic [XW-1:0] pw, ph;
	always_comb begin
		pw = (XW'(in_data.tex_width) + (XW'(in_data.border) << 1) + XW'(3)) & ~XW'(3);
		ph = (XW'(in_data.tex_height) + (XW'(in_data.border) << 1) + XW'(3)) & ~XW'(3);
	end

	rect_t full_r, boot_r;
	always_comb begin
		full_r = full_rect(atlas_w_q, atlas_h_q);
		boot_r = full_rect(ATLAS_RESET, ATLAS_RESET);
	end

	// Next strip of the current scratch entry: left, top, right, bottom.
	logic [2:0] fsel;
	rect_t frag_r;
	logic frag_ok;
	always_comb begin
		frag_r = f_q;
		frag_ok = 1'b1;
		fsel = frag_q;
		priority if (frag_q == 3'd0 && f_q.x0 < best_q.x0) begin
			fsel = 3'd0; frag_r.x1 = best_q.x0;
		end else if (frag_q <= 3'd1 && f_q.z0 < best_q.z0) begin
			fsel = 3'd1; frag_r.z1 = best_q.z0;
		end else if (frag_q <= 3'd2 && f_q.x1 > best_q.x1) begin
			fsel = 3'd2; frag_r.x0 = best_q.x1;
		end else if (frag_q <= 3'd3 && f_q.z1 > best_q.z1) begin
			fsel = 3'd3; frag_r.z0 = best_q.z1;
		end else begin
			fsel = 3'd4; frag_ok = 1'b0;
		end
	end

	// Where an insertion returns to: a reset request is finished, a split
	// goes on with the next strip.
	state_t ret_state;
	assign ret_state = (cmd_q == CMD_RESET) ? S_DONE : S_FRAG;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_BOOT: state_d = S_IDLE;
			S_IDLE: if (in_valid) begin
				state_d = (in_data.command == CMD_RESET) ? S_COV_RD : S_SEARCH_RD;
			end
			S_SEARCH_RD: begin
				if (idx_q >= count_q) state_d = found_q ? S_COPY_RD : S_DONE;
				else state_d = S_SEARCH;
			end
			S_SEARCH: state_d = S_SEARCH_RD;
			S_COPY_RD: state_d = (idx_q >= count_q) ? S_SPLIT_RD : S_COPY;
			S_COPY: state_d = S_COPY_RD;
			S_SPLIT_RD: state_d = (idx_q >= n_q) ? S_DONE : S_SPLIT;
			S_SPLIT: state_d = apart ? S_COV_RD : S_FRAG;
			S_FRAG: state_d = frag_ok ? S_COV_RD : S_SPLIT_RD;
			S_COV_RD: state_d = (ins_idx_q >= count_q) ? S_PRUNE_RD : S_COV;
			S_COV: state_d = covered ? ret_state : S_COV_RD;
			S_PRUNE_RD: state_d = (ins_idx_q >= count_q) ? S_APPEND : S_PRUNE;
			S_PRUNE: state_d = S_PRUNE_RD;
			S_APPEND: state_d = ret_state;
			S_DONE: if (!out_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs and datapath.
	always_comb begin
		count_d = count_q;
		idx_d = idx_q;
		ins_idx_d = ins_idx_q;
		wr_d = wr_q;
		n_d = n_q;
		frag_d = frag_q;
		found_d = found_q;
		drop_d = drop_q;
		cmd_d = cmd_q;
		out_valid_d = out_valid_q;
		best_d = best_q;
		f_d = f_q;
		ins_d = ins_q;
		need_w_d = need_w_q;
		need_h_d = need_h_q;
		border_d = border_q;
		rsp_d = rsp_q;
		free_we = 1'b0;
		free_waddr = '0;
		free_wdata = '0;
		free_raddr = idx_q[AW-1:0];
		scr_we = 1'b0;
		scr_waddr = '0;
		scr_wdata = '0;
		scr_raddr = idx_q[AW-1:0];

		unique case (state_q)
			S_BOOT: begin
				free_we = 1'b1;
				free_wdata = pack_r(boot_r);
			end
			S_IDLE: if (in_valid) begin
				cmd_d = in_data.command;
				drop_d = 1'b0;
				found_d = 1'b0;
				idx_d = '0;
				need_w_d = pw;
				need_h_d = ph;
				border_d = in_data.border;
				if (in_data.command == CMD_RESET) begin
					count_d = '0;
					ins_idx_d = '0;
					ins_d = full_r;
				end
			end
			S_SEARCH_RD: begin
				if (idx_q >= count_q) begin
					idx_d = '0;
					if (!found_q) begin
						rsp_d = '0;
						rsp_d.status = ST_NOFIT;
						out_valid_d = 1'b1;
					end
				end
			end
			S_SEARCH: begin
				if (fits && better) begin
					best_d.x0 = c_r.x0;
					best_d.z0 = c_r.z0;
					best_d.x1 = c_r.x0 + need_w_q;
					best_d.z1 = c_r.z0 + need_h_q;
					found_d = 1'b1;
				end
				idx_d = idx_q + CW'(1);
			end
			S_COPY_RD: begin
				if (idx_q >= count_q) begin
					n_d = count_q;
					count_d = '0;
					idx_d = '0;
				end
			end
			S_COPY: begin
				scr_we = 1'b1;
				scr_waddr = idx_q[AW-1:0];
				scr_wdata = free_rd_q;
				idx_d = idx_q + CW'(1);
			end
			S_SPLIT_RD: begin
				if (idx_q >= n_q) begin
					rsp_d = '0;
					rsp_d.status = drop_q ? ST_DROP : ST_OK;
					rsp_d.left = FIELD_W'(best_q.x0 + XW'(border_q));
					rsp_d.top = FIELD_W'(best_q.z0 + XW'(border_q));
					rsp_d.right = FIELD_W'(best_q.x1 - XW'(border_q));
					rsp_d.bottom = FIELD_W'(best_q.z1 - XW'(border_q));
					out_valid_d = 1'b1;
				end
			end
			S_SPLIT: begin
				// An entry clear of the placement goes back in whole.
				f_d = s_r;
				frag_d = '0;
				if (apart) begin
					ins_d = s_r;
					frag_d = 3'd4;
					ins_idx_d = '0;
				end
			end
			S_FRAG: begin
				if (frag_ok) begin
					ins_d = frag_r;
					frag_d = fsel + 3'd1;
					ins_idx_d = '0;
				end else begin
					idx_d = idx_q + CW'(1);
				end
			end
			S_COV_RD: begin
				free_raddr = ins_idx_q[AW-1:0];
				if (ins_idx_q >= count_q) begin
					ins_idx_d = '0;
					wr_d = '0;
				end
			end
			S_COV: begin
				if (!covered) begin
					ins_idx_d = ins_idx_q + CW'(1);
				end else if (cmd_q == CMD_RESET) begin
					rsp_d = '0;
					rsp_d.status = ST_OK;
					out_valid_d = 1'b1;
				end
			end
			S_PRUNE_RD: free_raddr = ins_idx_q[AW-1:0];
			S_PRUNE: begin
				if (!contained) begin
					free_we = 1'b1;
					free_waddr = wr_q[AW-1:0];
					free_wdata = free_rd_q;
					wr_d = wr_q + CW'(1);
				end
				ins_idx_d = ins_idx_q + CW'(1);
			end
			S_APPEND: begin
				if (wr_q >= CNT_MAX) begin
					drop_d = 1'b1;
					count_d = wr_q;
				end else begin
					free_we = 1'b1;
					free_waddr = wr_q[AW-1:0];
					free_wdata = pack_r(ins_q);
					count_d = wr_q + CW'(1);
				end
				if (cmd_q == CMD_RESET) begin
					rsp_d = '0;
					rsp_d.status = (wr_q >= CNT_MAX) ? ST_DROP : ST_OK;
					out_valid_d = 1'b1;
				end
			end
			S_DONE: if (!out_stall) out_valid_d = 1'b0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_BOOT;
			count_q <= CW'(1);
			idx_q <= '0;
			ins_idx_q <= '0;
			wr_q <= '0;
			n_q <= '0;
			frag_q <= '0;
			found_q <= 1'b0;
			drop_q <= 1'b0;
			cmd_q <= 1'b0;
			out_valid_q <= 1'b0;
			best_q <= '0;
			f_q <= '0;
			ins_q <= '0;
			need_w_q <= '0;
			need_h_q <= '0;
			border_q <= '0;
			rsp_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q <= idx_d;
			ins_idx_q <= ins_idx_d;
			wr_q <= wr_d;
			n_q <= n_d;
			frag_q <= frag_d;
			found_q <= found_d;
			drop_q <= drop_d;
			cmd_q <= cmd_d;
			out_valid_q <= out_valid_d;
			best_q <= best_d;
			f_q <= f_d;
			ins_q <= ins_d;
			need_w_q <= need_w_d;
			need_h_q <= need_h_d;
			border_q <= border_d;
			rsp_q <= rsp_d;
		end
	end

endmodule

@@ design/mraa_checker.sv @@
module mraa_checker
	import mraa_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input rsp_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("response dropped or changed while stalled");

	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("request taken while a response is pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block not busy after taking a request");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status <= ST_DROP)
		else $error("illegal status");

	a_nofit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_NOFIT |-> out_data.left == '0 &&
		out_data.top == '0 && out_data.right == '0 && out_data.bottom == '0)
		else $error("no-fit response carries edges");

endmodule

bind maxrects_atlas_allocator_core mraa_checker u_mraa_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

@@ tb/sv/maxrects_atlas_allocator_core_tb.sv @@
`timescale 1ns / 100ps

// Testbench for the maxrects atlas allocator.
// A scoreboard class keeps its own copy of the free-rectangle list and of the
// atlas size registers. For every request taken by the block it works out the
// response (placement, fragment split with pruning, drop status) and queues it.
// Every response taken from the block is compared field by field with the
// oldest queued one.
module maxrects_atlas_allocator_core_tb;
	import mraa_pkg::*;

	localparam int LIST_DEPTH = MAX_FREE_RECTS_DEF;
	localparam int unsigned EDGE_MAX = (1 << COORD_BITS_DEF) - 1;

	typedef struct {
		int unsigned x0, z0, x1, z1;
	} box_t;

	// The scoreboard holds the predicted free list and the queue of expected
	// responses.
	class atlas_scoreboard;
		box_t free_list[LIST_DEPTH];
		box_t scratch[LIST_DEPTH];
		int unsigned free_n;
		int unsigned atlas_w, atlas_h;
		bit lost_strip;
		rsp_t pending_rsp[$];
		int errors;

		function void clear_state();
			atlas_w = ATLAS_RESET;
			atlas_h = ATLAS_RESET;
			errors = 0;
			rebuild_list();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == REG_ATLAS_WIDTH) begin
				atlas_w = val;
			end else if (idx == REG_ATLAS_HEIGHT) begin
				atlas_h = val;
			end
		endfunction

		// Add a strip unless a free rectangle already covers it; anything the
		// strip covers is pruned first. A strip that finds the list full is lost.
		function void insert_box(box_t r);
			int unsigned keep;
			keep = 0;
			for (int i = 0; i < free_n; i++) begin
				if (free_list[i].x0 <= r.x0 && free_list[i].x1 >= r.x1 &&
				    free_list[i].z0 <= r.z0 && free_list[i].z1 >= r.z1)
					return;
			end
			for (int i = 0; i < free_n; i++) begin
				if (!(r.x0 <= free_list[i].x0 && r.x1 >= free_list[i].x1 &&
				      r.z0 <= free_list[i].z0 && r.z1 >= free_list[i].z1)) begin
					free_list[keep] = free_list[i];
					keep++;
				end
			end
			free_n = keep;
			if (free_n >= LIST_DEPTH) begin
				lost_strip = 1'b1;
				return;
			end
			free_list[free_n] = r;
			free_n++;
		endfunction

		function void rebuild_list();
			box_t full;
			full.x0 = 0;
			full.z0 = 0;
			full.x1 = (atlas_w > EDGE_MAX) ? EDGE_MAX : atlas_w;
			full.z1 = (atlas_h > EDGE_MAX) ? EDGE_MAX : atlas_h;
			free_n = 0;
			insert_box(full);
		endfunction

		// Cut every free rectangle that overlaps the placement into its
		// left, top, right and bottom strips.
		function void carve(box_t a);
			int unsigned n;
			box_t f, g;
			bit apart;
			n = free_n;
			for (int i = 0; i < n; i++)
				scratch[i] = free_list[i];
			free_n = 0;
			for (int i = 0; i < n; i++) begin
				f = scratch[i];
				apart = a.x0 >= f.x1 || f.x0 >= a.x1 || a.z0 >= f.z1 || f.z0 >= a.z1 ||
				        a.x0 >= a.x1 || a.z0 >= a.z1 || f.x0 >= f.x1 || f.z0 >= f.z1;
				if (apart) begin
					insert_box(f);
				end else begin
					if (f.x0 < a.x0) begin
						g = f; g.x1 = a.x0; insert_box(g);
					end
					if (f.z0 < a.z0) begin
						g = f; g.z1 = a.z0; insert_box(g);
					end
					if (f.x1 > a.x1) begin
						g = f; g.x0 = a.x1; insert_box(g);
					end
					if (f.z1 > a.z1) begin
						g = f; g.z0 = a.z1; insert_box(g);
					end
				end
			end
		endfunction

		// Called for every request the block takes.
		function void note_request(req_t req);
			rsp_t rsp;
			int unsigned need_w, need_h, cw, ch, b;
			bit found;
			box_t best;
			rsp = '0;
			lost_strip = 1'b0;
			found = 1'b0;
			best = '{0, 0, 0, 0};
			b = req.border;
			if (req.command == CMD_RESET) begin
				rebuild_list();
				rsp.status = lost_strip ? ST_DROP : ST_OK;
			end else begin
				need_w = (int'(req.tex_width) + 2 * b + 3) & ~32'd3;
				need_h = (int'(req.tex_height) + 2 * b + 3) & ~32'd3;
				for (int i = 0; i < free_n; i++) begin
					cw = (free_list[i].x1 >= free_list[i].x0) ?
					     free_list[i].x1 - free_list[i].x0 : 0;
					ch = (free_list[i].z1 >= free_list[i].z0) ?
					     free_list[i].z1 - free_list[i].z0 : 0;
					if (need_w <= cw && need_h <= ch) begin
						if (!found || free_list[i].z0 < best.z0 ||
						    (free_list[i].z0 == best.z0 && free_list[i].x0 < best.x0)) begin
							best.x0 = free_list[i].x0;
							best.z0 = free_list[i].z0;
							best.x1 = free_list[i].x0 + need_w;
							best.z1 = free_list[i].z0 + need_h;
							found = 1'b1;
						end
					end
				end
				if (!found) begin
					rsp.status = ST_NOFIT;
				end else begin
					carve(best);
					rsp.status = lost_strip ? ST_DROP : ST_OK;
					rsp.left = FIELD_W'(best.x0 + b);
					rsp.top = FIELD_W'(best.z0 + b);
					rsp.right = FIELD_W'(best.x1 - b);
					rsp.bottom = FIELD_W'(best.z1 - b);
				end
			end
			pending_rsp = {pending_rsp, rsp};
		endfunction

		// Called for every response the block hands out.
		function void check_response(rsp_t got);
			rsp_t want;
			if (pending_rsp.size() == 0) begin
				$display("%0t: response with none expected: %p", $time, got);
				errors++;
				return;
			end
			want = pending_rsp.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				errors++;
			end
			if (got.left !== want.left) begin
				$display("%0t: left expected %0d actual %0d", $time, want.left, got.left);
				errors++;
			end
			if (got.top !== want.top) begin
				$display("%0t: top expected %0d actual %0d", $time, want.top, got.top);
				errors++;
			end
			if (got.right !== want.right) begin
				$display("%0t: right expected %0d actual %0d", $time, want.right, got.right);
				errors++;
			end
			if (got.bottom !== want.bottom) begin
				$display("%0t: bottom expected %0d actual %0d", $time,
				         want.bottom, got.bottom);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	req_t in_data;
	logic out_valid;
	logic out_stall;
	rsp_t out_data;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	atlas_scoreboard sb;
	bit quiet;       // no random idling on either side while set
	bit hold_go;     // asks the receiver for one long hold-off
	bit stim_done;

	maxrects_atlas_allocator_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver side: random stalls, plus one long hold-off on request so that
	// the block sits on a finished response while the sender keeps offering.
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !quiet && ($urandom_range(99) < 9);
			end
		end
	end

	// Every response taken is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_response(out_data);
	end

	// Offers one request and returns at the edge where it is taken. The valid
	// stays high afterwards so a following request can go back to back.
	task automatic send_request(req_t req);
		if (!quiet && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request(req);
	endtask

	// Waits until every predicted response has been seen, then a little more.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_rsp.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Both size registers are written in consecutive cycles while idle.
	task automatic set_atlas(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_ATLAS_WIDTH;
		cfg_data <= w;
		sb.write_reg(REG_ATLAS_WIDTH, w);
		@(posedge clk);
		cfg_index <= REG_ATLAS_HEIGHT;
		cfg_data <= h;
		sb.write_reg(REG_ATLAS_HEIGHT, h);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic req_t make_req(logic [0:0] cmd, int unsigned tw, int unsigned th,
	                                  int unsigned b);
		req_t r;
		r.command = cmd;
		r.tex_width = FIELD_W'(tw);
		r.tex_height = FIELD_W'(th);
		r.border = BORDER_W'(b);
		return r;
	endfunction

	// Mostly small textures so the free list grows in depth; now and then a
	// reset, a full-range size or a wide border.
	function automatic req_t random_req();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 6)
			return make_req(CMD_RESET, $urandom_range(0, 8191), $urandom_range(0, 8191),
			                $urandom_range(0, 255));
		if (pick < 14)
			return make_req(CMD_ALLOC, $urandom_range(0, 8191), $urandom_range(0, 8191),
			                $urandom_range(0, 255));
		if (pick < 22)
			return make_req(CMD_ALLOC, $urandom_range(1, 300), $urandom_range(1, 300),
			                $urandom_range(0, 40));
		return make_req(CMD_ALLOC, $urandom_range(1, 40), $urandom_range(1, 40),
		                $urandom_range(0, 3));
	endfunction

	initial begin
		sb = new();
		sb.clear_state();
		quiet = 1'b0;
		hold_go = 1'b0;
		stim_done = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = REG_ATLAS_WIDTH;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on the reset-time atlas size: zero padded size, widest
		// border, largest texture, a texture that cannot fit, a full-atlas
		// placement that empties the list, and reset commands.
		send_request(make_req(CMD_ALLOC, 0, 0, 0));
		send_request(make_req(CMD_ALLOC, 1, 1, 0));
		send_request(make_req(CMD_ALLOC, 8191, 8191, 255));
		send_request(make_req(CMD_ALLOC, 4096, 1, 0));
		send_request(make_req(CMD_ALLOC, 1, 1, 255));
		send_request(make_req(CMD_ALLOC, 5, 3, 1));
		send_request(make_req(CMD_RESET, 8191, 8191, 255));
		send_request(make_req(CMD_ALLOC, 1024, 1024, 0));
		send_request(make_req(CMD_ALLOC, 1, 1, 0));
		send_request(make_req(CMD_RESET, 0, 0, 0));
		send_request(make_req(CMD_ALLOC, 1000, 1000, 0));
		send_request(make_req(CMD_ALLOC, 24, 24, 0));
		send_request(make_req(CMD_ALLOC, 2, 2, 1));
		drain();

		// Phases over several atlas sizes, extremes among them. Register writes
		// only show after the reset command that opens each phase.
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_atlas(13'd4, 13'd4);
				1: set_atlas(13'd4096, 13'd4096);
				2: set_atlas(13'd4096, 13'd4);
				3: set_atlas(13'd64, 13'd200);
				4: set_atlas(13'd8191, 13'd1);
				default: set_atlas(CFG_DATA_W'($urandom_range(4, 4096)),
				                   CFG_DATA_W'($urandom_range(4, 4096)));
			endcase
			if (phase == 0)
				send_request(make_req(CMD_ALLOC, 1, 1, 0));
			send_request(make_req(CMD_RESET, 0, 0, 0));
			quiet = (phase == 2);
			if (phase == 3)
				hold_go = 1'b1;
			for (int n = 0; n < 21; n++)
				send_request(random_req());
			drain();
			quiet = 1'b0;
		end
		stim_done = 1'b1;
	end

	initial begin
		wait (stim_done);
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#1000ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ files.f @@
design/mraa_pkg.sv
design/maxrects_atlas_allocator_core.sv
design/mraa_checker.sv
tb/sv/maxrects_atlas_allocator_core_tb.sv
